>>> hw/rtl/cat_pkg.sv
// Shared types, sizes and codes for the client activity table.
// No dependencies; imported by cat_ctrl, cat_dp and client_activity_table_unit.
package cat_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = 32;
    localparam int TIME_W   = 32;
    localparam int WIN_W    = 16;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd60;

    localparam logic OP_TOUCH = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] OUT_NONE     = 2'd0;
    localparam logic [1:0] OUT_REFRESH  = 2'd1;
    localparam logic [1:0] OUT_INSERT   = 2'd2;
    localparam logic [1:0] OUT_REPLACED = 2'd3;

    localparam logic [7:0] OCT_10  = 8'd10;
    localparam logic [7:0] OCT_172 = 8'd172;
    localparam logic [7:0] OCT_192 = 8'd192;
    localparam logic [7:0] OCT_168 = 8'd168;
    localparam logic [7:0] OCT_16  = 8'd16;
    localparam logic [7:0] OCT_31  = 8'd31;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic skip_scan;
        logic scan_done;
        logic out_free;
    } t_sts;

    // 10/8, 172.16/12, 192.168/16
    function automatic logic addr_private(input logic [ADDR_W-1:0] a);
        logic [7:0] o1;
        logic [7:0] o2;
        o1 = a[31:24];
        o2 = a[23:16];
        return (o1 == OCT_192 && o2 == OCT_168) || (o1 == OCT_10) ||
               (o1 == OCT_172 && (o2 inside {[OCT_16:OCT_31]}));
    endfunction

endpackage

>>> hw/rtl/cat_ctrl.sv
// Sequencer for the client activity table: load, scan, commit.
// Depends on cat_pkg (t_cmd, t_sts).
module cat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  cat_pkg::t_sts i_sts,
    output cat_pkg::t_cmd o_cmd
);
    import cat_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.skip_scan || i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the result register to be free
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/cat_dp.sv
// Datapath: slot memories, scan pipeline, oldest search and result register.
// Depends on cat_pkg; driven by cat_ctrl through t_cmd / t_sts.
module cat_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cat_pkg::t_cmd            i_cmd,
    output cat_pkg::t_sts            o_sts,
    input  logic                     i_op,
    input  logic [cat_pkg::ADDR_W-1:0] i_addr,
    input  logic [cat_pkg::TIME_W-1:0] i_now,
    input  logic                     i_cfg_we,
    input  logic [cat_pkg::WIN_W-1:0]  i_cfg_wdata,
    input  logic                     i_m_tready,
    output logic                     o_m_tvalid,
    output logic [1:0]               o_outcome,
    output logic                     o_found,
    output logic                     o_online
);
    import cat_pkg::*;

    logic [ADDR_W-1:0] mem_addr [CAPACITY];
    logic [TIME_W-1:0] mem_time [CAPACITY];

    logic              r_op;
    logic              r_priv;
    logic [ADDR_W-1:0] r_addr;
    logic [TIME_W-1:0] r_now;
    logic [WIN_W-1:0]  r_window;
    logic [CNT_W-1:0]  r_used;

    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [TIME_W-1:0] r_rd_time;

    logic              r_match;
    logic [IDX_W-1:0]  r_match_idx;
    logic [TIME_W-1:0] r_match_time;
    logic [IDX_W-1:0]  r_old_idx;
    logic [TIME_W-1:0] r_old_time;

    logic              r_out_vld;
    logic [1:0]        r_out_outcome;
    logic              r_out_found;
    logic              r_out_online;

    logic              issue;
    logic              full;
    logic              is_touch;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [TIME_W-1:0] diff;
    logic              online;
    logic [1:0]        outcome;

    assign issue    = i_cmd.scan && (r_rd_idx < r_used) && !r_match;
    assign full     = (r_used == CNT_W'(CAPACITY));
    assign is_touch = (r_op == OP_TOUCH);
    assign diff     = r_now - r_match_time;
    assign online   = r_match && (diff[TIME_W-1] || (diff <= TIME_W'(r_window)));
    assign wr_en    = i_cmd.commit && is_touch && r_priv;

    always_comb begin
        if (r_match) begin
            wr_idx  = r_match_idx;
            outcome = OUT_REFRESH;
        end else if (!full) begin
            wr_idx  = r_used[IDX_W-1:0];
            outcome = OUT_INSERT;
        end else begin
            wr_idx  = r_old_idx;
            outcome = OUT_REPLACED;
        end
    end

    assign o_sts.skip_scan = is_touch && !r_priv;
    assign o_sts.scan_done = ((r_rd_idx >= r_used) || r_match) && !r_cmp_vld;
    assign o_sts.out_free  = !r_out_vld || i_m_tready;

    // slot memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_addr[wr_idx] <= r_addr;
            mem_time[wr_idx] <= r_now;
        end
        r_rd_addr <= mem_addr[r_rd_idx[IDX_W-1:0]];
        r_rd_time <= mem_time[r_rd_idx[IDX_W-1:0]];
    end

    // item payload and search results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_addr <= i_addr;
            r_now  <= i_now;
            r_priv <= addr_private(i_addr);
        end
        r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        if (r_cmp_vld) begin
            if (r_rd_addr == r_addr && !r_match) begin
                r_match_idx  <= r_cmp_idx;
                r_match_time <= r_rd_time;
            end
            // strict less-than keeps the lowest index on ties
            if (r_cmp_idx == '0 || r_rd_time < r_old_time) begin
                r_old_idx  <= r_cmp_idx;
                r_old_time <= r_rd_time;
            end
        end
        if (i_cmd.commit) begin
            r_out_outcome <= (is_touch && r_priv) ? outcome : OUT_NONE;
            r_out_found   <= r_match;
            r_out_online  <= !is_touch && online;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_RESET;
            r_used    <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_match   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
                r_match   <= 1'b0;
            end else begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                if (r_cmp_vld && r_rd_addr == r_addr) begin
                    r_match <= 1'b1;
                end
            end
            if (wr_en && !r_match && !full) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_outcome  = r_out_outcome;
    assign o_found    = r_out_found;
    assign o_online   = r_out_online;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !r_match && !full) |=> (r_used == $past(r_used) + 1'b1))
        else $error("insert did not advance the fill count");

    a_online_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_online) |-> (r_out_found && r_out_outcome == OUT_NONE))
        else $error("online reported without a found query");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_rd_idx <= r_used))
        else $error("scan read past the filled slots");

endmodule

>>> hw/rtl/client_activity_table_unit.sv
// Client activity table: one item per table scan, one entry compared per cycle.
// Each accepted item is loaded, then the filled slots (0..16) are read in index order through
// the registered read port and compared, ending early on a match; an empty table or a
// non-private touch skips the scan. A new item is accepted only after the last one commits;
// a result not yet taken holds the current item before commit. Reset (i_rst_n low, sync)
// empties the table and sets the window to 60 s. Depends on cat_pkg, cat_ctrl and cat_dp.
module client_activity_table_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [63:0]                  i_s_tdata,   // address[31:0], now[63:32]
    input  logic                         i_s_tuser,   // op
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [7:0]                   o_m_tdata,   // outcome[1:0], found[2], online[3]
    input  logic                         i_cfg_we,
    input  logic [cat_pkg::WIN_W-1:0]    i_cfg_wdata
);
    import cat_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic [1:0] outcome;
    logic       found;
    logic       online;

    cat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cat_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_s_tuser),
        .i_addr      (i_s_tdata[ADDR_W-1:0]),
        .i_now       (i_s_tdata[ADDR_W+TIME_W-1:ADDR_W]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_outcome   (outcome),
        .o_found     (found),
        .o_online    (online)
    );

    assign o_m_tdata = {4'b0000, online, found, outcome};

endmodule
